// ----- hw/rtl/pearson_correlation_accumulator_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef PEARSON_CORRELATION_ACCUMULATOR_ASSERT_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_ASSERT_SVH

// Checked only while reset is released.
`define PCA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/pca_pkg.sv -----
package pca_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int CNT_W       = 17;
    localparam int MAX_SAMPLES = 65536;
    localparam int SUM1_W      = 40;
    localparam int SUM2_W      = 64;
    localparam int VAR_W       = 82;
    localparam int D_W         = 164;
    localparam int PROD_W      = 200;
    localparam int MB_W        = 100;
    localparam int NB_W        = 7;
    localparam int K_W         = 16;
    localparam int BI_W        = 4;
    localparam int SQ_W        = 32;
    localparam int CORR_W      = 16;
    localparam int STAT_W      = 2;
    localparam int MIN_RESET   = 10;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZVAR = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd3;

    localparam logic [NB_W-1:0] NB_SAMPLE = 7'd24;
    localparam logic [NB_W-1:0] NB_CNT    = 7'd17;
    localparam logic [NB_W-1:0] NB_SUM1   = 7'd40;
    localparam logic [NB_W-1:0] NB_VAR    = 7'd82;
    localparam logic [NB_W-1:0] NB_L      = 7'd97;
    localparam logic [NB_W-1:0] NB_O      = 7'd16;
    localparam logic [NB_W-1:0] NB_SQ     = 7'd32;

    typedef enum logic [4:0] {
        S_IDLE, S_MXY, S_MXX, S_MYY, S_CHK, S_VX1, S_VX2, S_VY1, S_VY2, S_ZCHK,
        S_D, S_P, S_Q, S_L2, S_SQ, S_R, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic            start;
        logic [NB_W-1:0] nbits;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_rsp;

endpackage

// ----- hw/rtl/pca_mul.sv -----
module pca_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pca_pkg::t_mul_req           i_req,
    input  logic [pca_pkg::PROD_W-1:0]  i_a,
    input  logic [pca_pkg::MB_W-1:0]    i_b,
    output pca_pkg::t_mul_rsp           o_rsp,
    output logic [pca_pkg::PROD_W-1:0]  o_prod
);
    import pca_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [NB_W-1:0]   r_cnt;
    logic [PROD_W-1:0] r_a;
    logic [MB_W-1:0]   r_b;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] n_acc;

    assign n_acc = r_b[0] ? r_acc + r_a : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NB_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_acc <= n_acc;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_prod     = r_acc;

endmodule

// ----- hw/rtl/pearson_correlation_accumulator.sv -----
// Channel   Beat fields                          Handshake
// input     i_x_sample, i_y_sample, i_last       i_valid / o_stall
// output    o_correlation, o_status,             o_valid / i_stall
//           o_sample_count
// config    i_cfg_data (min_count)               i_cfg_we
//
// Each sample beat accepted below full count runs three 24-bit products on the shared
// shift-add multiplier, each a start, one shift-add step per bit and a done pulse.
// A beat that arrives at full count is dropped in its accept cycle.
// A last beat, with no beat dropped and min_count met, goes on to the variance terms,
// the squared numerator and a 16-step coefficient search, all on the same multiplier.
// Reset is synchronous and active low; it clears the sums and sets min_count to 10.
// A result held by i_stall keeps the block busy until the output register frees.
module pearson_correlation_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pca_pkg::SAMPLE_W-1:0]  i_x_sample,
    input  logic [pca_pkg::SAMPLE_W-1:0]  i_y_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [pca_pkg::CORR_W-1:0] o_correlation,
    output logic [pca_pkg::STAT_W-1:0]    o_status,
    output logic [pca_pkg::CNT_W-1:0]     o_sample_count,
    input  logic                          i_cfg_we,
    input  logic [pca_pkg::CNT_W-1:0]     i_cfg_data
);
    import pca_pkg::*;

    t_state            r_state, n_state;
    logic              r_issued;
    logic [CNT_W-1:0]  r_min_count;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic              r_last;
    logic [SAMPLE_W-1:0] r_x, r_y;
    logic [SUM1_W-1:0] r_sx, r_sy;
    logic [SUM2_W-1:0] r_sxy, r_sxx, r_syy;
    logic [VAR_W-1:0]  r_tmp, r_vx, r_vy, r_num;
    logic              r_neg;
    logic [D_W-1:0]    r_d;
    logic [PROD_W-1:0] r_l2;
    logic [K_W-1:0]    r_k;
    logic [BI_W-1:0]   r_bi;
    logic [SQ_W-1:0]   r_sq;
    logic [STAT_W-1:0] r_status;
    logic [CORR_W-1:0] r_corr;
    logic              r_ovalid;

    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;
    logic [PROD_W-1:0] mul_a, mul_b_w, mul_prod;
    logic              is_mul;
    logic              accept, out_free, full;
    logic [K_W-1:0]    cand;
    logic              cand_skip;
    logic [K_W-1:0]    odd;
    logic [VAR_W-1:0]  q_val;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign out_free  = !r_ovalid || !i_stall;
    assign full      = (r_count == CNT_W'(MAX_SAMPLES));
    assign cand      = r_k | (K_W'(1) << r_bi);
    assign cand_skip = cand[K_W-1] && (cand[K_W-2:0] != '0);
    assign odd       = K_W'(({1'b0, cand} << 1) - (K_W+1)'(1));
    assign q_val     = mul_prod[VAR_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                if (full) n_state = i_last ? S_CHK : S_IDLE;
                else      n_state = S_MXY;
            end
            S_MXY: if (mul_rsp.done) n_state = S_MXX;
            S_MXX: if (mul_rsp.done) n_state = S_MYY;
            S_MYY: if (mul_rsp.done) n_state = r_last ? S_CHK : S_IDLE;
            S_CHK: n_state = (r_ovf || (r_count < r_min_count)) ? S_OUT : S_VX1;
            S_VX1: if (mul_rsp.done) n_state = S_VX2;
            S_VX2: if (mul_rsp.done) n_state = S_VY1;
            S_VY1: if (mul_rsp.done) n_state = S_VY2;
            S_VY2: if (mul_rsp.done) n_state = S_ZCHK;
            S_ZCHK: n_state = ((r_vx == '0) || (r_vy == '0)) ? S_OUT : S_D;
            S_D:   if (mul_rsp.done) n_state = S_P;
            S_P:   if (mul_rsp.done) n_state = S_Q;
            S_Q:   if (mul_rsp.done) n_state = S_L2;
            S_L2:  if (mul_rsp.done) n_state = S_SQ;
            S_SQ: begin
                if (cand_skip)         n_state = (r_bi == '0) ? S_FIN : S_SQ;
                else if (mul_rsp.done) n_state = S_R;
            end
            S_R:   if (mul_rsp.done) n_state = (r_bi == '0) ? S_FIN : S_SQ;
            S_FIN: n_state = S_OUT;
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        is_mul        = 1'b1;
        mul_a         = '0;
        mul_b_w       = '0;
        mul_req.nbits = NB_SAMPLE;
        unique case (r_state)
            S_MXY: begin mul_a = PROD_W'(r_x); mul_b_w = PROD_W'(r_y); end
            S_MXX: begin mul_a = PROD_W'(r_x); mul_b_w = PROD_W'(r_x); end
            S_MYY: begin mul_a = PROD_W'(r_y); mul_b_w = PROD_W'(r_y); end
            S_VX1: begin
                mul_a = PROD_W'(r_sxx); mul_b_w = PROD_W'(r_count); mul_req.nbits = NB_CNT;
            end
            S_VX2: begin
                mul_a = PROD_W'(r_sx); mul_b_w = PROD_W'(r_sx); mul_req.nbits = NB_SUM1;
            end
            S_VY1: begin
                mul_a = PROD_W'(r_syy); mul_b_w = PROD_W'(r_count); mul_req.nbits = NB_CNT;
            end
            S_VY2: begin
                mul_a = PROD_W'(r_sy); mul_b_w = PROD_W'(r_sy); mul_req.nbits = NB_SUM1;
            end
            S_D: begin
                mul_a = PROD_W'(r_vx); mul_b_w = PROD_W'(r_vy); mul_req.nbits = NB_VAR;
            end
            S_P: begin
                mul_a = PROD_W'(r_sxy); mul_b_w = PROD_W'(r_count); mul_req.nbits = NB_CNT;
            end
            S_Q: begin
                mul_a = PROD_W'(r_sx); mul_b_w = PROD_W'(r_sy); mul_req.nbits = NB_SUM1;
            end
            S_L2: begin
                mul_a = PROD_W'(r_num) << 16; mul_b_w = PROD_W'(r_num) << 16;
                mul_req.nbits = NB_L;
            end
            S_SQ: begin
                mul_a = PROD_W'(odd); mul_b_w = PROD_W'(odd); mul_req.nbits = NB_O;
                is_mul = !cand_skip;
            end
            S_R: begin
                mul_a = PROD_W'(r_d); mul_b_w = PROD_W'(r_sq); mul_req.nbits = NB_SQ;
            end
            default: is_mul = 1'b0;
        endcase
        mul_req.start = is_mul && !r_issued;
    end

    pca_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b_w[MB_W-1:0]),
        .o_rsp   (mul_rsp),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_min_count <= CNT_W'(MIN_RESET);
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxy       <= '0;
            r_sxx       <= '0;
            r_syy       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_req.start)     r_issued <= 1'b1;
            else if (mul_rsp.done) r_issued <= 1'b0;
            if (i_cfg_we) r_min_count <= i_cfg_data;
            if ((r_state == S_OUT) && out_free) r_ovalid <= 1'b1;
            else if (!i_stall)                  r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_sx    <= r_sx + SUM1_W'(i_x_sample);
                        r_sy    <= r_sy + SUM1_W'(i_y_sample);
                    end
                end
                S_MXY: if (mul_rsp.done) r_sxy <= r_sxy + mul_prod[SUM2_W-1:0];
                S_MXX: if (mul_rsp.done) r_sxx <= r_sxx + mul_prod[SUM2_W-1:0];
                S_MYY: if (mul_rsp.done) r_syy <= r_syy + mul_prod[SUM2_W-1:0];
                S_OUT: if (out_free) begin
                    r_count  <= '0;
                    r_ovf    <= 1'b0;
                    r_sx     <= '0;
                    r_sy     <= '0;
                    r_sxy    <= '0;
                    r_sxx    <= '0;
                    r_syy    <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_x_sample;
            r_y    <= i_y_sample;
            r_last <= i_last;
        end
        case (r_state)
            S_CHK: begin
                r_corr   <= '0;
                r_status <= r_ovf ? ST_OVF : ST_FEW;
            end
            S_VX1, S_VY1, S_P: if (mul_rsp.done) r_tmp <= q_val;
            S_VX2: if (mul_rsp.done) r_vx <= r_tmp - q_val;
            S_VY2: if (mul_rsp.done) r_vy <= r_tmp - q_val;
            S_ZCHK: r_status <= ST_ZVAR;
            S_D: if (mul_rsp.done) r_d <= mul_prod[D_W-1:0];
            S_Q: if (mul_rsp.done) begin
                r_neg <= (r_tmp < q_val);
                r_num <= (r_tmp < q_val) ? q_val - r_tmp : r_tmp - q_val;
            end
            S_L2: if (mul_rsp.done) begin
                r_l2 <= mul_prod;
                r_k  <= '0;
                r_bi <= BI_W'(K_W - 1);
            end
            S_SQ: begin
                if (cand_skip)         r_bi <= r_bi - 1'b1;
                else if (mul_rsp.done) r_sq <= mul_prod[SQ_W-1:0];
            end
            S_R: if (mul_rsp.done) begin
                if (r_l2 >= mul_prod) r_k <= cand;
                r_bi <= r_bi - 1'b1;
            end
            S_FIN: begin
                r_status <= ST_OK;
                if (r_neg)            r_corr <= -r_k;
                else if (r_k[K_W-1])  r_corr <= {1'b0, {(CORR_W-1){1'b1}}};
                else                  r_corr <= r_k;
            end
            S_OUT: if (out_free) begin
                o_correlation  <= r_corr;
                o_status       <= r_status;
                o_sample_count <= r_count;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;

endmodule

// ----- hw/rtl/pca_checker.sv -----
`include "pearson_correlation_accumulator_assert.svh"

module pca_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [pca_pkg::CORR_W-1:0] o_correlation,
    input logic [pca_pkg::STAT_W-1:0]    o_status,
    input logic [pca_pkg::CNT_W-1:0]     o_sample_count
);
    import pca_pkg::*;

    `PCA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `PCA_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_correlation) && $stable(o_status) && $stable(o_sample_count), "stalled beat changed")
    `PCA_ASSERT(a_zero_corr, i_clk, i_rst_n, o_valid && (o_status != ST_OK) |-> o_correlation == '0, "nonzero coefficient with error status")
    `PCA_ASSERT(a_ovf_count, i_clk, i_rst_n, o_valid && (o_status == ST_OVF) |-> o_sample_count == CNT_W'(MAX_SAMPLES), "overflow below full count")
    `PCA_ASSERT(a_ok_count, i_clk, i_rst_n, o_valid && (o_status == ST_OK) |-> o_sample_count >= CNT_W'(2), "coefficient from fewer than two pairs")

endmodule

bind pearson_correlation_accumulator pca_checker u_pca_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_correlation  (o_correlation),
    .o_status       (o_status),
    .o_sample_count (o_sample_count)
);
